// ===== src/bcsl_pkg.sv =====
package bcsl_pkg;

  // direction codes
  localparam logic [1:0] DIR_UNKNOWN = 2'd0;
  localparam logic [1:0] DIR_FWD     = 2'd1;
  localparam logic [1:0] DIR_REV     = 2'd2;

  // drive mode codes
  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_REV  = 2'd2;

  // register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTOR_ORIGIN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_MODE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_TICKS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNTS_WIN   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D       = 3'd6;

  // register reset values
  localparam logic [15:0] COUNTS_WIN_RESET = 16'd120;
  localparam logic [15:0] GAIN_P_RESET     = 16'd256;
  localparam logic [5:0]  DRIVE_RESET      = 6'h12;

  // fixed-point widths of the speed loop
  localparam int unsigned ERR_W   = 25;
  localparam int unsigned INTEG_W = 32;
  localparam int unsigned DIFF_W  = ERR_W + 1;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned PP_W    = GAIN_W + ERR_W;
  localparam int unsigned PI_W    = GAIN_W + INTEG_W;
  localparam int unsigned PD_W    = GAIN_W + DIFF_W;

  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // result queue depth
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [2:0]              rotor_origin;
    logic [1:0]              drive_mode;
    logic [23:0]             target_ticks;
    logic [15:0]             counts_per_window;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
  } cfg_t;

  typedef struct packed {
    logic hall_one;
    logic hall_two;
    logic hall_three;
    logic quad_a;
    logic quad_b;
  } tick_in_t;

  typedef struct packed {
    logic [5:0]         drive_word;
    logic signed [31:0] position;
    logic [1:0]         direction;
    logic               speed_updated;
  } tick_res_t;

  typedef struct packed {
    logic                      zero_duty;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integral;
    logic signed [DIFF_W-1:0]  diff;
  } pid_op_t;

  typedef struct packed {
    logic [5:0]         drive_word;
    logic [DUTY_W-1:0]  duty;
    logic signed [31:0] position;
    logic [1:0]         direction;
    logic               speed_updated;
  } out_item_t;

  // hall code to rotor state
  function automatic logic [2:0] rotor_map(input logic [2:0] code);
    logic [2:0] r;
    case (code)
      3'd0:    r = 3'd7;
      3'd1:    r = 3'd5;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd4;
      3'd4:    r = 3'd1;
      3'd5:    r = 3'd0;
      3'd6:    r = 3'd2;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  // drive state to phase legs
  function automatic logic [5:0] drive_map(input logic [2:0] st);
    logic [5:0] w;
    case (st)
      3'd0:    w = 6'h12;
      3'd1:    w = 6'h18;
      3'd2:    w = 6'h09;
      3'd3:    w = 6'h21;
      3'd4:    w = 6'h24;
      3'd5:    w = 6'h06;
      default: w = 6'h00;
    endcase
    return w;
  endfunction

  // remainder by six for values up to fifteen
  function automatic logic [2:0] mod6(input logic [3:0] s);
    logic [3:0] r;
    if (s >= 4'd12) begin
      r = s - 4'd12;
    end else if (s >= 4'd6) begin
      r = s - 4'd6;
    end else begin
      r = s;
    end
    return r[2:0];
  endfunction

  function automatic logic [1:0] mode_dir(input logic [1:0] mode);
    logic [1:0] d;
    case (mode)
      MODE_FWD: d = DIR_FWD;
      MODE_REV: d = DIR_REV;
      default:  d = DIR_UNKNOWN;
    endcase
    return d;
  endfunction

  function automatic logic signed [2:0] mode_lead(input logic [1:0] mode);
    logic signed [2:0] l;
    case (mode)
      MODE_FWD: l = 3'sd1;
      MODE_REV: l = -3'sd2;
      default:  l = 3'sd0;
    endcase
    return l;
  endfunction

endpackage

// ===== src/bcsl_if.sv =====
interface bcsl_in_if;
  logic valid;
  logic ready;
  logic hall_one;
  logic hall_two;
  logic hall_three;
  logic quad_a;
  logic quad_b;

  modport source(output valid, hall_one, hall_two, hall_three, quad_a, quad_b,
                 input ready);
  modport sink(input valid, hall_one, hall_two, hall_three, quad_a, quad_b,
               output ready);
endinterface

interface bcsl_out_if;
  logic              valid;
  logic              ready;
  logic [5:0]        drive_word;
  logic [15:0]       duty;
  logic signed [31:0] position;
  logic [1:0]        direction;
  logic              speed_updated;

  modport source(output valid, drive_word, duty, position, direction, speed_updated,
                 input ready);
  modport sink(input valid, drive_word, duty, position, direction, speed_updated,
               output ready);
endinterface

// ===== src/bcsl_tick.sv =====
module bcsl_tick #(
  parameter int unsigned ELAPSED_WIDTH  = 24,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  bcsl_pkg::cfg_t     cfg,
  input  logic               in_take,
  input  bcsl_pkg::tick_in_t in_bits,
  output logic               res_valid,
  output bcsl_pkg::tick_res_t res,
  output bcsl_pkg::pid_op_t  op
);
  import bcsl_pkg::*;

  localparam int unsigned EW = ELAPSED_WIDTH;
  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned XW = ((EW > 24) ? EW : 24) + 2;
  localparam int unsigned CW = PW + 16;

  // input register
  logic     p0_valid;
  tick_in_t p0;

  // tick state
  logic                      prev_a;
  logic                      prev_b;
  logic [PW-1:0]             count;
  logic [1:0]                dir_state;
  logic [2:0]                prev_rotor;
  logic [5:0]                drive_hold;
  logic [PW-1:0]             window_start;
  logic                      window_active;
  logic [1:0]                win_dir;
  logic [EW-1:0]             elapsed;
  logic signed [ERR_W-1:0]   last_err;
  logic signed [INTEG_W-1:0] integral;

  logic                      ea, eb, step, up;
  logic [PW-1:0]             count_next;
  logic [1:0]                dir_next;
  logic [2:0]                rotor;
  logic signed [4:0]         rsum;
  logic [5:0]                drive_next;
  logic [EW-1:0]             elapsed_inc;
  logic [PW-1:0]             prog;
  logic                      close;
  logic signed [XW-1:0]      err_wide;
  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [DIFF_W-1:0]  diff;
  logic [63:0]               count64;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else begin
      p0_valid <= in_take;
    end
    if (in_take) begin
      p0 <= in_bits;
    end
  end

  // quadrature decode that counts every edge of either channel
  always_comb begin
    ea   = p0.quad_a ^ prev_a;
    eb   = p0.quad_b ^ prev_b;
    step = ea ^ eb;
    up   = ea ? (p0.quad_a ^ p0.quad_b) : ~(p0.quad_a ^ p0.quad_b);
    if (step) begin
      count_next = up ? count + PW'(1) : count - PW'(1);
      dir_next   = up ? DIR_FWD : DIR_REV;
    end else begin
      count_next = count;
      dir_next   = dir_state;
    end
  end

  // hall commutation
  always_comb begin
    rotor = rotor_map({p0.hall_three, p0.hall_two, p0.hall_one});
    rsum  = $signed({2'b00, rotor}) - $signed({2'b00, cfg.rotor_origin})
          + 5'(mode_lead(cfg.drive_mode)) + 5'sd6;
    if (rotor != prev_rotor) begin
      drive_next = rsum[4] ? 6'h00 : drive_map(mod6(rsum[3:0]));
    end else begin
      drive_next = drive_hold;
    end
  end

  // window progress and close
  always_comb begin
    elapsed_inc = (elapsed == {EW{1'b1}}) ? elapsed : elapsed + EW'(1);
    prog  = (win_dir == DIR_FWD) ? count_next - window_start : window_start - count_next;
    close = window_active && !prog[PW-1] && (CW'(prog) >= CW'(cfg.counts_per_window));
  end

  // error, integral and difference with saturation
  always_comb begin
    err_wide = $signed(XW'(elapsed_inc)) - $signed(XW'(cfg.target_ticks));
    if (err_wide[XW-1:ERR_W-1] != {(XW-ERR_W+1){err_wide[XW-1]}}) begin
      err = err_wide[XW-1] ? ERR_MIN : ERR_MAX;
    end else begin
      err = err_wide[ERR_W-1:0];
    end
    integ_sum = {integral[INTEG_W-1], integral} + (INTEG_W+1)'(err);
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end
    diff    = DIFF_W'(err) - DIFF_W'(last_err);
    count64 = 64'(count_next);
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_a        <= 1'b0;
      prev_b        <= 1'b0;
      count         <= '0;
      dir_state     <= DIR_UNKNOWN;
      prev_rotor    <= 3'd0;
      drive_hold    <= DRIVE_RESET;
      window_start  <= '0;
      window_active <= 1'b0;
      win_dir       <= DIR_UNKNOWN;
      elapsed       <= '0;
      last_err      <= '0;
      integral      <= '0;
    end else if (p0_valid) begin
      prev_a     <= p0.quad_a;
      prev_b     <= p0.quad_b;
      count      <= count_next;
      dir_state  <= dir_next;
      prev_rotor <= rotor;
      drive_hold <= drive_next;
      if (window_active && !close) begin
        elapsed <= elapsed_inc;
      end else if (dir_next != DIR_UNKNOWN) begin
        window_active <= 1'b1;
        window_start  <= count_next;
        win_dir       <= dir_next;
        elapsed       <= '0;
      end else begin
        window_active <= 1'b0;
      end
      if (close) begin
        last_err <= err;
        integral <= integ_sat;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= p0_valid;
    end
    if (p0_valid) begin
      res.drive_word    <= drive_next;
      res.position      <= count64[31:0];
      res.direction     <= dir_next;
      res.speed_updated <= close;
      op.zero_duty      <= (mode_dir(cfg.drive_mode) == DIR_UNKNOWN)
                        || (dir_next != mode_dir(cfg.drive_mode));
      op.err            <= err;
      op.integral       <= integ_sat;
      op.diff           <= diff;
    end
  end

endmodule

// ===== src/bcsl_pid.sv =====
module bcsl_pid (
  input  logic                clk,
  input  logic                rst,
  input  bcsl_pkg::cfg_t      cfg,
  input  logic                duty_clear,
  input  logic                op_valid,
  input  bcsl_pkg::tick_res_t res,
  input  bcsl_pkg::pid_op_t   op,
  output logic                push,
  output bcsl_pkg::out_item_t item
);
  import bcsl_pkg::*;

  localparam int unsigned SUM_W = PI_W + 2;
  localparam int unsigned DACC_W = SUM_W + 1;

  // product stage
  logic                   v2;
  tick_res_t              res2;
  logic                   zero2;
  logic signed [PP_W-1:0] pp;
  logic signed [PI_W-1:0] pi;
  logic signed [PD_W-1:0] pd;

  logic [DUTY_W-1:0]        duty_acc;
  logic [DUTY_W-1:0]        duty_clamp;
  logic [DUTY_W-1:0]        duty_acc_next;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  corr;
  logic signed [DACC_W-1:0] dsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= op_valid;
    end
    if (op_valid) begin
      res2  <= res;
      zero2 <= op.zero_duty;
      pp    <= cfg.gain_p * op.err;
      pi    <= cfg.gain_i * op.integral;
      pd    <= cfg.gain_d * op.diff;
    end
  end

  // correction, floor by 256, accumulate and clamp
  always_comb begin
    sum  = SUM_W'(pp) + SUM_W'(pi) + SUM_W'(pd);
    corr = sum >>> 8;
    dsum = $signed({{(DACC_W-DUTY_W){1'b0}}, duty_acc}) + DACC_W'(corr);
    if (dsum[DACC_W-1]) begin
      duty_clamp = '0;
    end else if (|dsum[DACC_W-2:DUTY_W]) begin
      duty_clamp = {DUTY_W{1'b1}};
    end else begin
      duty_clamp = dsum[DUTY_W-1:0];
    end
    if (v2 && res2.speed_updated) begin
      duty_acc_next = zero2 ? '0 : duty_clamp;
    end else begin
      duty_acc_next = duty_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_acc <= '0;
    end else if (duty_clear) begin
      duty_acc <= '0;
    end else begin
      duty_acc <= duty_acc_next;
    end
  end

  // beat toward the result queue
  assign push               = v2;
  assign item.drive_word    = res2.drive_word;
  assign item.duty          = duty_acc_next;
  assign item.position      = res2.position;
  assign item.direction     = res2.direction;
  assign item.speed_updated = res2.speed_updated;

endmodule

// ===== src/bcsl_out_fifo.sv =====
module bcsl_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  bcsl_pkg::out_item_t           item,
  output logic [bcsl_pkg::FIFO_CNT_W-1:0] fill,
  bcsl_out_if.source                    out
);
  import bcsl_pkg::*;

  out_item_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;
  out_item_t             head;

  assign pop  = out.valid && out.ready;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      fill <= fill + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  // head of queue drives the output channel
  assign out.valid         = (fill != '0);
  assign out.drive_word    = head.drive_word;
  assign out.duty          = head.duty;
  assign out.position      = head.position;
  assign out.direction     = head.direction;
  assign out.speed_updated = head.speed_updated;

endmodule

// ===== src/bldc_commutation_speed_loop_core.sv =====
// an accepted input beat passes the input register, the tick result register and the
// product stage into the result queue; one input beat per cycle while input ready is high
// an 8-entry result queue with credit counting sets when input ready drops
// reset (rst, synchronous, active high) restores register defaults, clears the
// position, window and loop state and empties the queue; no clearing pass
module bldc_commutation_speed_loop_core #(
  parameter int unsigned ELAPSED_WIDTH  = 24,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  bcsl_in_if.sink                            in,
  bcsl_out_if.source                         out,
  input  logic                               cfg_write,
  input  logic [bcsl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bcsl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bcsl_pkg::*;

  cfg_t                  cfg;
  logic                  in_take;
  tick_in_t              in_bits;
  logic                  res_valid;
  tick_res_t             res;
  pid_op_t               op;
  logic                  push;
  out_item_t             item;
  logic [FIFO_CNT_W-1:0] fill;
  logic [1:0]            inflight;
  logic                  duty_clear;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotor_origin      <= 3'd0;
      cfg.drive_mode        <= MODE_FWD;
      cfg.target_ticks      <= 24'd0;
      cfg.counts_per_window <= COUNTS_WIN_RESET;
      cfg.gain_p            <= GAIN_P_RESET;
      cfg.gain_i            <= '0;
      cfg.gain_d            <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROTOR_ORIGIN: cfg.rotor_origin      <= cfg_data[2:0];
        REG_DRIVE_MODE:   cfg.drive_mode        <= cfg_data[1:0];
        REG_TARGET_TICKS: cfg.target_ticks      <= cfg_data[23:0];
        REG_COUNTS_WIN:   cfg.counts_per_window <= cfg_data[15:0];
        REG_GAIN_P:       cfg.gain_p            <= cfg_data[15:0];
        REG_GAIN_I:       cfg.gain_i            <= cfg_data[15:0];
        REG_GAIN_D:       cfg.gain_d            <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // a drive mode write of stop, or of any code with no direction, clears the duty accumulator
  assign duty_clear = cfg_write && (cfg_index == REG_DRIVE_MODE)
                   && (mode_dir(cfg_data[1:0]) == DIR_UNKNOWN);

  // credit check: every beat in flight has a queue slot waiting
  assign in.ready = ((5'(fill) + 5'(inflight)) < 5'(FIFO_DEPTH));
  assign in_take  = in.valid && in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 2'd0;
    end else begin
      inflight <= inflight + 2'(in_take) - 2'(push);
    end
  end

  assign in_bits.hall_one   = in.hall_one;
  assign in_bits.hall_two   = in.hall_two;
  assign in_bits.hall_three = in.hall_three;
  assign in_bits.quad_a     = in.quad_a;
  assign in_bits.quad_b     = in.quad_b;

  bcsl_tick #(
    .ELAPSED_WIDTH (ELAPSED_WIDTH),
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_tick (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_take  (in_take),
    .in_bits  (in_bits),
    .res_valid(res_valid),
    .res      (res),
    .op       (op)
  );

  bcsl_pid u_pid (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .duty_clear(duty_clear),
    .op_valid  (res_valid),
    .res       (res),
    .op        (op),
    .push      (push),
    .item      (item)
  );

  bcsl_out_fifo u_fifo (
    .clk (clk),
    .rst (rst),
    .push(push),
    .item(item),
    .fill(fill),
    .out (out)
  );

endmodule

// ===== src/bcsl_checker.sv =====
module bcsl_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] drive_word,
  input logic [1:0] direction,
  input logic       speed_updated
);
  import bcsl_pkg::*;

  logic seen_known;

  // remember that a known direction has been shown
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_known <= 1'b0;
    end else if (out_valid && out_ready && (direction != DIR_UNKNOWN)) begin
      seen_known <= 1'b1;
    end
  end

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // a stalled beat stays offered
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // drive word is all off or has exactly two legs set
  a_drive_legs: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (($countones(drive_word) == 2) || (drive_word == 6'h00)))
    else $error("drive word with illegal leg pattern");

  // a window only closes with a known direction
  a_update_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && speed_updated |-> (direction != DIR_UNKNOWN))
    else $error("speed update without known direction");

  // once known, the direction never falls back to unknown
  a_dir_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_known |-> (direction != DIR_UNKNOWN))
    else $error("direction returned to unknown");

endmodule

bind bldc_commutation_speed_loop_core bcsl_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out.valid),
  .out_ready    (out.ready),
  .drive_word   (out.drive_word),
  .direction    (out.direction),
  .speed_updated(out.speed_updated)
);
